@@ src/ntpt_pkg.sv @@
// Package for the note-to-PWM tone timing block: shared types and constants.
// Used by the top level and by its port checker; depends on nothing.
package ntpt_pkg;

   localparam int HZ_W      = 16;
   localparam int CODE_W    = 16;
   localparam int TEMPO_W   = 10;
   localparam int SYSCLK_W  = 27;
   localparam int COUNT_W   = SYSCLK_W + 4;
   localparam int WHOLE_W   = 18;
   localparam int QUO3_W    = 20;
   localparam int MS_W      = 19;
   localparam int DIV_W     = 16;
   localparam int TIME_W    = 29;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYSCLK = 1'b1;

   localparam logic [TEMPO_W-1:0]  TEMPO_RESET  = 10'd140;
   localparam logic [SYSCLK_W-1:0] SYSCLK_RESET = 27'd125000000;

   localparam logic [WHOLE_W-1:0] WHOLE_MS_1BPM   = 18'd240000;
   localparam logic [DIV_W-1:0]   DIV_MIN         = 16'd16;
   localparam logic [TIME_W-1:0]  SOUND_US_PER_MS = 29'd900;
   localparam logic [TIME_W-1:0]  QUIET_US_PER_MS = 29'd100;
   localparam logic [TIME_W-1:0]  REST_US_PER_MS  = 29'd1000;

   // count / 60000 = (count >> 5) / 1875, done as a reciprocal multiply:
   // ceil(2^37 / 1875) is exact for every 26-bit scaled count.
   localparam int DIV_SHIFT   = 5;
   localparam int SCALED_W    = COUNT_W - DIV_SHIFT;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 37;
   localparam int PROD_W      = SCALED_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd73300776;

   // Per-note context that rides alongside the divider chain.
   typedef struct packed {
      logic                melody_end;
      logic                tone_active;
      logic                dotted;
      logic [CODE_W-1:0]   mag;
      logic [COUNT_W-1:0]  count;
      logic [WHOLE_W-1:0]  whole;
      logic [MS_W-1:0]     ms;
      logic [DIV_W-1:0]    divider;
   } note_ctx_type;

endpackage

@@ src/ntpt_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
// Carries an opaque sideband word along with each division; no package use.
module ntpt_div_pipe #(
   parameter int NumW  = 31,
   parameter int DenW  = 16,
   parameter int SideW = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [NumW-1:0]  in_num,
   input  logic [DenW-1:0]  in_den,
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   output logic [NumW-1:0]  out_quo,
   output logic [SideW-1:0] out_side
);

   logic             valid_ff [NumW];
   logic [DenW-1:0]  rem_ff  [NumW];
   logic [NumW-1:0]  num_ff  [NumW];
   logic [DenW-1:0]  den_ff  [NumW];
   logic [SideW-1:0] side_ff [NumW];

   for (genvar g = 0; g < NumW; g++) begin : g_stage
      logic             v_src;
      logic [DenW-1:0]  rem_src;
      logic [NumW-1:0]  num_src;
      logic [DenW-1:0]  den_src;
      logic [SideW-1:0] side_src;
      logic [DenW:0]    trial;
      logic [DenW:0]    diff;
      logic             fits;
      logic [DenW-1:0]  rem_in;
      logic [NumW-1:0]  num_in;

      if (g == 0) begin : g_head
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign num_src  = in_num;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_body
         assign v_src    = valid_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign num_src  = num_ff[g-1];
         assign den_src  = den_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      // shift in the next dividend bit, subtract if the divisor fits
      assign trial  = {rem_src, num_src[NumW-1]};
      assign diff   = trial - {1'b0, den_src};
      assign fits   = trial >= {1'b0, den_src};
      assign rem_in = fits ? diff[DenW-1:0] : trial[DenW-1:0];
      assign num_in = {num_src[NumW-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (advance) begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g]  <= rem_in;
            num_ff[g]  <= num_in;
            den_ff[g]  <= den_src;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NumW-1];
   assign out_quo   = num_ff[NumW-1];
   assign out_side  = side_ff[NumW-1];

endmodule

@@ src/note_to_pwm_tone_timing.sv @@
// Top level of the note-to-PWM tone timing block.
// Uses ntpt_pkg and four ntpt_div_pipe dividers chained into one pipeline.
//
//   channel | direction | handshake          | word
//   req_    | in        | req_valid/ready    | note_hz, length_code, sound_enabled
//   rsp_    | out       | rsp_valid/ready    | divider, top, level, times, end flag
//   csr_    | in        | csr_valid/ready    | index (0 tempo, 1 sysclk), wdata
//
// One word enters per cycle while the output is not stalled. Each word passes
// the bit-per-stage dividers: 31 (count) + 18 (whole) + 20 (note ms) stages, one
// reciprocal-multiply stage for the PWM divider, 31 (top) stages, and then the
// output register.
// Synchronous active-high reset empties every stage; registers return to
// 140 bpm and 125 MHz. A stalled output freezes the whole pipeline in place.
module note_to_pwm_tone_timing (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_note_hz,
   input  logic signed [15:0] req_length_code,
   input  logic        req_sound_enabled,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_clock_divider,
   output logic [15:0] rsp_wrap_top,
   output logic [14:0] rsp_duty_level,
   output logic        rsp_tone_active,
   output logic [28:0] rsp_sound_time_us,
   output logic [28:0] rsp_quiet_time_us,
   output logic        rsp_melody_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ntpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ntpt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CtxW = $bits(ntpt_pkg::note_ctx_type);

   logic [ntpt_pkg::TEMPO_W-1:0]  tempo_ff;
   logic [ntpt_pkg::SYSCLK_W-1:0] sysclk_ff;
   logic advance;

   // Configuration: always ready, masked to register width.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff  <= ntpt_pkg::TEMPO_RESET;
         sysclk_ff <= ntpt_pkg::SYSCLK_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ntpt_pkg::CSR_TEMPO:  tempo_ff  <= csr_wdata[ntpt_pkg::TEMPO_W-1:0];
            ntpt_pkg::CSR_SYSCLK: sysclk_ff <= csr_wdata[ntpt_pkg::SYSCLK_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance whenever the output register is empty or being drained.
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Entry: decode the length code and flags.
   ntpt_pkg::note_ctx_type ctx0;
   logic [15:0] code_u;
   logic [15:0] mag_raw;
   logic [15:0] hz_den;

   assign code_u  = req_length_code;
   assign mag_raw = code_u[15] ? 16'(~code_u + 16'd1) : code_u;
   assign hz_den  = (req_note_hz == '0) ? 16'd1 : req_note_hz;

   always_comb begin
      ctx0             = '0;
      ctx0.melody_end  = (code_u == '0);
      ctx0.tone_active = (req_note_hz != '0) && req_sound_enabled && (code_u != '0);
      ctx0.dotted      = code_u[15];
      ctx0.mag         = (mag_raw == '0) ? 16'd1 : mag_raw;
   end

   // count = sysclk * 16 / hz
   logic                   d1_valid;
   logic [ntpt_pkg::COUNT_W-1:0] d1_quo;
   ntpt_pkg::note_ctx_type d1_ctx;

   ntpt_div_pipe #(.NumW(ntpt_pkg::COUNT_W), .DenW(16), .SideW(CtxW)) u_div_count (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid && advance),
      .in_num({sysclk_ff, 4'b0000}), .in_den(hz_den), .in_side(ctx0),
      .out_valid(d1_valid), .out_quo(d1_quo), .out_side(d1_ctx)
   );

   // whole note ms = 240000 / tempo (tempo zero acts as one)
   ntpt_pkg::note_ctx_type ctx1;
   logic [ntpt_pkg::TEMPO_W-1:0] tempo_den;
   logic                   d2_valid;
   logic [ntpt_pkg::WHOLE_W-1:0] d2_quo;
   ntpt_pkg::note_ctx_type d2_ctx;

   assign tempo_den = (tempo_ff == '0) ? ntpt_pkg::TEMPO_W'(1) : tempo_ff;

   always_comb begin
      ctx1       = d1_ctx;
      ctx1.count = d1_quo;
   end

   ntpt_div_pipe #(.NumW(ntpt_pkg::WHOLE_W), .DenW(ntpt_pkg::TEMPO_W), .SideW(CtxW))
   u_div_whole (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(d1_valid), .in_num(ntpt_pkg::WHOLE_MS_1BPM), .in_den(tempo_den),
      .in_side(ctx1),
      .out_valid(d2_valid), .out_quo(d2_quo), .out_side(d2_ctx)
   );

   // note ms = whole / code, or 3 * whole / |code| for a dotted note
   ntpt_pkg::note_ctx_type ctx2;
   logic [ntpt_pkg::QUO3_W-1:0] whole_x;
   logic [ntpt_pkg::QUO3_W-1:0] ms_num;
   logic                   d3_valid;
   logic [ntpt_pkg::QUO3_W-1:0] d3_quo;
   ntpt_pkg::note_ctx_type d3_ctx;

   assign whole_x = ntpt_pkg::QUO3_W'(d2_quo);
   assign ms_num  = d2_ctx.dotted ? ((whole_x << 1) + whole_x) : whole_x;

   always_comb begin
      ctx2       = d2_ctx;
      ctx2.whole = d2_quo;
   end

   ntpt_div_pipe #(.NumW(ntpt_pkg::QUO3_W), .DenW(16), .SideW(CtxW)) u_div_ms (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(d2_valid), .in_num(ms_num), .in_den(d2_ctx.mag), .in_side(ctx2),
      .out_valid(d3_valid), .out_quo(d3_quo), .out_side(d3_ctx)
   );

   // divider = count / 60000 by reciprocal multiply; halve the dotted
   // quotient on the way in
   ntpt_pkg::note_ctx_type ctx3;
   logic [ntpt_pkg::SCALED_W-1:0] count_scaled;
   logic [ntpt_pkg::PROD_W-1:0]   recip_prod_in;
   logic [ntpt_pkg::PROD_W-1:0]   recip_prod_ff;
   logic                          d4_valid_ff;
   ntpt_pkg::note_ctx_type        d4_ctx_ff;
   logic [ntpt_pkg::DIV_W-1:0]    d4_quo;

   always_comb begin
      ctx3    = d3_ctx;
      ctx3.ms = d3_ctx.dotted ? d3_quo[ntpt_pkg::MS_W:1] : d3_quo[ntpt_pkg::MS_W-1:0];
   end

   assign count_scaled  = d3_ctx.count[ntpt_pkg::COUNT_W-1:ntpt_pkg::DIV_SHIFT];
   assign recip_prod_in = ntpt_pkg::PROD_W'(count_scaled)
                          * ntpt_pkg::PROD_W'(ntpt_pkg::DIV_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         d4_valid_ff <= 1'b0;
      end else if (advance) begin
         d4_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         recip_prod_ff <= recip_prod_in;
         d4_ctx_ff     <= ctx3;
      end
   end

   assign d4_quo = recip_prod_ff[ntpt_pkg::RECIP_SHIFT +: ntpt_pkg::DIV_W];

   // clamp the divider to its floor, then top = count / divider
   ntpt_pkg::note_ctx_type ctx4;
   logic [ntpt_pkg::DIV_W-1:0] div_clamped;
   logic                   d5_valid;
   logic [ntpt_pkg::COUNT_W-1:0] d5_quo;
   ntpt_pkg::note_ctx_type d5_ctx;

   assign div_clamped = (d4_quo < ntpt_pkg::DIV_MIN) ? ntpt_pkg::DIV_MIN : d4_quo;

   always_comb begin
      ctx4         = d4_ctx_ff;
      ctx4.divider = div_clamped;
   end

   ntpt_div_pipe #(.NumW(ntpt_pkg::COUNT_W), .DenW(ntpt_pkg::DIV_W), .SideW(CtxW))
   u_div_top (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(d4_valid_ff), .in_num(d4_ctx_ff.count), .in_den(div_clamped),
      .in_side(ctx4),
      .out_valid(d5_valid), .out_quo(d5_quo), .out_side(d5_ctx)
   );

   // Output stage: pick tone, rest or end-of-melody, scale ms to us.
   logic [ntpt_pkg::TIME_W-1:0] ms_ext;
   logic [15:0] clock_divider_in, wrap_top_in;
   logic [14:0] duty_level_in;
   logic        tone_active_in, melody_end_in;
   logic [ntpt_pkg::TIME_W-1:0] sound_in, quiet_in;
   logic [15:0] clock_divider_ff, wrap_top_ff;
   logic [14:0] duty_level_ff;
   logic        tone_active_ff, melody_end_ff;
   logic [ntpt_pkg::TIME_W-1:0] sound_ff, quiet_ff;

   assign ms_ext = ntpt_pkg::TIME_W'(d5_ctx.ms);

   always_comb begin
      clock_divider_in = '0;
      wrap_top_in      = '0;
      duty_level_in    = '0;
      tone_active_in   = 1'b0;
      melody_end_in    = 1'b0;
      sound_in         = '0;
      quiet_in         = '0;
      priority if (d5_ctx.melody_end) begin
         melody_end_in = 1'b1;
      end else if (d5_ctx.tone_active) begin
         clock_divider_in = d5_ctx.divider;
         wrap_top_in      = d5_quo[15:0];
         duty_level_in    = d5_quo[15:1];
         tone_active_in   = 1'b1;
         sound_in         = ms_ext * ntpt_pkg::SOUND_US_PER_MS;
         quiet_in         = ms_ext * ntpt_pkg::QUIET_US_PER_MS;
      end else begin
         quiet_in         = ms_ext * ntpt_pkg::REST_US_PER_MS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d5_valid;
      end
   end

   // hold the word while the consumer stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         clock_divider_ff <= clock_divider_in;
         wrap_top_ff      <= wrap_top_in;
         duty_level_ff    <= duty_level_in;
         tone_active_ff   <= tone_active_in;
         melody_end_ff    <= melody_end_in;
         sound_ff         <= sound_in;
         quiet_ff         <= quiet_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clock_divider = clock_divider_ff;
   assign rsp_wrap_top      = wrap_top_ff;
   assign rsp_duty_level    = duty_level_ff;
   assign rsp_tone_active   = tone_active_ff;
   assign rsp_sound_time_us = sound_ff;
   assign rsp_quiet_time_us = quiet_ff;
   assign rsp_melody_end    = melody_end_ff;

endmodule

@@ src/ntpt_checker.sv @@
// Port-level checker for note_to_pwm_tone_timing, bound to the top level.
// Uses ntpt_pkg for the divider floor.
module ntpt_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_clock_divider,
   input logic [15:0] rsp_wrap_top,
   input logic        rsp_tone_active,
   input logic [28:0] rsp_sound_time_us,
   input logic        rsp_melody_end
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_clock_divider))
      else $error("stalled result word changed");

   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_melody_end |-> !rsp_tone_active && rsp_clock_divider == '0
                                      && rsp_sound_time_us == '0)
      else $error("end-of-melody word carries tone data");

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tone_active |-> rsp_wrap_top == '0 && rsp_sound_time_us == '0)
      else $error("silent word carries tone data");

   a_div_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tone_active |-> rsp_clock_divider >= ntpt_pkg::DIV_MIN)
      else $error("divider below floor on a sounding note");

endmodule

bind note_to_pwm_tone_timing ntpt_port_checker u_ntpt_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_clock_divider(rsp_clock_divider), .rsp_wrap_top(rsp_wrap_top),
   .rsp_tone_active(rsp_tone_active), .rsp_sound_time_us(rsp_sound_time_us),
   .rsp_melody_end(rsp_melody_end)
);

@@ sim/ntpt_checker.sv @@
// Result checker for the note-to-PWM tone timing block: predicts each note's
// PWM settings and times, compares the rsp_ words in order. Uses ntpt_pkg.
`timescale 1ns / 100ps
module ntpt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_note_hz,
   input  logic signed [15:0] req_length_code,
   input  logic        req_sound_enabled,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_clock_divider,
   input  logic [15:0] rsp_wrap_top,
   input  logic [14:0] rsp_duty_level,
   input  logic        rsp_tone_active,
   input  logic [28:0] rsp_sound_time_us,
   input  logic [28:0] rsp_quiet_time_us,
   input  logic        rsp_melody_end,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [ntpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ntpt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int          error_count,
   output int          pending_notes
);

   typedef struct packed {
      logic [15:0] divider;
      logic [15:0] top;
      logic [14:0] level;
      logic        active;
      logic [28:0] sound_us;
      logic [28:0] quiet_us;
      logic        last;
   } tone_word_type;

   logic [ntpt_pkg::TEMPO_W-1:0]  tempo_q;
   logic [ntpt_pkg::SYSCLK_W-1:0] sysclk_q;
   tone_word_type                 tone_q[$];

   function automatic tone_word_type predict_tone(logic [15:0] hz, logic [15:0] code,
                                                  logic en);
      tone_word_type w;
      longint whole, mag, ms, count, div, top;
      w = '0;
      if (code == 16'd0) begin
         w.last = 1'b1;
         return w;
      end
      whole = 240000 / ((tempo_q == 0) ? 1 : longint'(tempo_q));
      if (!code[15]) ms = whole / longint'(code);
      else begin
         mag = 65536 - longint'(code);
         ms = (3 * whole / mag) / 2;
      end
      if (hz != 0 && en) begin
         count = (longint'(sysclk_q) * 16) / longint'(hz);
         div = count / 60000;
         if (div < 16) div = 16;
         top = count / div;
         w.divider  = div[15:0];
         w.top      = top[15:0];
         w.level    = top[15:1];
         w.active   = 1'b1;
         w.sound_us = 29'(ms * 900);
         w.quiet_us = 29'(ms * 100);
      end else begin
         w.quiet_us = 29'(ms * 1000);
      end
      return w;
   endfunction

   assign pending_notes = tone_q.size();

   always @(posedge clock) begin
      tone_word_type got, exp_w;
      if (reset) begin
         tempo_q <= ntpt_pkg::TEMPO_RESET;
         sysclk_q <= ntpt_pkg::SYSCLK_RESET;
         error_count <= 0;
         tone_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ntpt_pkg::CSR_TEMPO)
               tempo_q <= csr_wdata[ntpt_pkg::TEMPO_W-1:0];
            else if (csr_index == ntpt_pkg::CSR_SYSCLK)
               sysclk_q <= csr_wdata[ntpt_pkg::SYSCLK_W-1:0];
         end
         if (req_valid && req_ready)
            tone_q.push_back(predict_tone(req_note_hz, req_length_code,
                                          req_sound_enabled));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_clock_divider, rsp_wrap_top, rsp_duty_level, rsp_tone_active,
                   rsp_sound_time_us, rsp_quiet_time_us, rsp_melody_end};
            if (tone_q.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               exp_w = tone_q.pop_front();
               if (got !== exp_w) begin
                  $display("%0t: exp div %0d top %0d lvl %0d act %0d snd %0d qt %0d end %0d",
                           $time, exp_w.divider, exp_w.top, exp_w.level, exp_w.active,
                           exp_w.sound_us, exp_w.quiet_us, exp_w.last);
                  $display("%0t: got div %0d top %0d lvl %0d act %0d snd %0d qt %0d end %0d",
                           $time, got.divider, got.top, got.level, got.active,
                           got.sound_us, got.quiet_us, got.last);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ sim/note_to_pwm_tone_timing_tb.sv @@
// Testbench top for the note-to-PWM tone timing block: drives notes and
// register writes, applies back-pressure. Uses ntpt_pkg and ntpt_checker.
`timescale 1ns / 100ps
module note_to_pwm_tone_timing_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_note_hz = '0;
   logic signed [15:0] req_length_code = '0;
   logic        req_sound_enabled = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_clock_divider;
   logic [15:0] rsp_wrap_top;
   logic [14:0] rsp_duty_level;
   logic        rsp_tone_active;
   logic [28:0] rsp_sound_time_us;
   logic [28:0] rsp_quiet_time_us;
   logic        rsp_melody_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [ntpt_pkg::CSR_IDX_W-1:0]  csr_index = ntpt_pkg::CSR_TEMPO;
   logic [ntpt_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int          error_count;
   int          pending_notes;

   // Idle rates in percent: the receiver reads recv_idle_pct each cycle, send_note reads send_idle_pct.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;
   bit press = 1'b0;

   always #5 clock = ~clock;

   note_to_pwm_tone_timing dut (.*);
   ntpt_checker chk (.*);

   // Receiver: random stalls, plus one long hold-off to fill the pipeline.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // Hold off while the sender streams with no gaps, so the input stalls.
   initial begin
      hold_off = 1'b0;
      wait (press);
      repeat (50) @(posedge clock);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   // Offer one note word; hold it until the block takes it.
   task automatic send_note(logic [15:0] hz, logic [15:0] code, logic en);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_note_hz <= hz;
      req_length_code <= code;
      req_sound_enabled <= en;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(logic [ntpt_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain: drop valid, wait for all results, then keep idling for safety.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_notes != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic random_note();
      logic [15:0] hz, code;
      int pick;
      pick = $urandom_range(99);
      hz = (pick < 10) ? 16'd0 : (pick < 60) ? 16'($urandom_range(20, 5000))
                                            : 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 3) code = 16'd0;
      else if (pick < 50) code = 16'($urandom_range(1, 32));
      else if (pick < 80) code = -16'($urandom_range(1, 32));
      else code = 16'($urandom);
      send_note(hz, code, $urandom_range(99) < 85);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed notes at reset settings: end marker, rests, extremes, dotted.
      send_note(16'd440, 16'd0, 1'b1);
      send_note(16'd0, 16'd4, 1'b1);
      send_note(16'd440, 16'd4, 1'b0);
      send_note(16'd1, 16'd1, 1'b1);
      send_note(16'hFFFF, 16'h7FFF, 1'b1);
      send_note(16'd262, -16'sd8, 1'b1);
      send_note(16'd523, 16'h8000, 1'b1);
      send_note(16'hFFFF, 16'hFFFF, 1'b1);
      send_note(16'h5555, 16'h5555, 1'b1);
      send_note(16'hAAAA, 16'hAAAA, 1'b0);
      send_note(16'd1000, 16'd1, 1'b1);
      drain();

      // Extreme registers: tempo 0 (as 1), clock 0, wide write data masked.
      write_csr(ntpt_pkg::CSR_TEMPO, 32'hFFFF_FC00);
      write_csr(ntpt_pkg::CSR_SYSCLK, 32'hF800_0000);
      send_note(16'd440, 16'd1, 1'b1);
      send_note(16'd440, -16'sd1, 1'b1);
      send_note(16'd0, 16'd2, 1'b1);
      drain();
      write_csr(ntpt_pkg::CSR_TEMPO, 32'd1023);
      write_csr(ntpt_pkg::CSR_SYSCLK, 32'd134000000);
      send_note(16'd1, 16'd1, 1'b1);
      send_note(16'd65535, -16'sd3, 1'b1);
      send_note(16'd20, 16'd1000, 1'b1);
      drain();

      // Random phases: receiver-heavy idling, sender-heavy, then none.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 79 : 0;
         recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 15 : 0;
         write_csr(ntpt_pkg::CSR_TEMPO,
                   (ph == 2) ? 32'd1 : 32'($urandom_range(1, 1023)));
         write_csr(ntpt_pkg::CSR_SYSCLK, 32'($urandom_range(1, 134000000)));
         if (ph == 2) press = 1'b1;
         for (int n = 0; n < 500; n++) random_note();
         drain();
      end

      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

@@ sim.f @@
src/ntpt_pkg.sv
src/ntpt_div_pipe.sv
src/note_to_pwm_tone_timing.sv
src/ntpt_checker.sv
sim/ntpt_checker.sv
sim/note_to_pwm_tone_timing_tb.sv
